// ===== src/cvsc_pkg.sv =====
// Shared widths, reset values and register codes for the capsule vote sum classifier.
package cvsc_pkg;

    // Field widths
    localparam int VOTE_W     = 8;
    localparam int IDX_W      = 4;
    localparam int ACC_W      = 24;
    localparam int SQ_W       = 15;
    localparam int ENERGY_W   = 15;
    localparam int RSH_W      = 5;
    localparam int ESH_W      = 3;
    localparam int ADDR_FULL_W = 8;

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROUTE_SHIFT  = 1'b0,
        REG_ENERGY_SHIFT = 1'b1
    } t_cfg_reg;

    localparam logic [RSH_W-1:0] ROUTE_SHIFT_RST  = 5'd11;
    localparam logic [ESH_W-1:0] ENERGY_SHIFT_RST = 3'd4;

    // Clip bounds and energy ceiling
    localparam logic signed [ACC_W-1:0] CLIP_HI = 24'sd127;
    localparam logic signed [ACC_W-1:0] CLIP_LO = -24'sd128;
    localparam logic [ENERGY_W-1:0]     ENERGY_MAX = 15'h7FFF;

    // Default geometry
    localparam int NUM_CLASSES_DEF = 10;
    localparam int CAPS_DIM_DEF    = 16;

endpackage

// ===== src/cvsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cvsc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 160
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/capsule_vote_sum_classify_unit.sv =====
// Capsule vote accumulator with per-class energy and running argmax (top level).
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-------------------------------------------
//  s_axis    | in  | tvalid / tready    | tdata: vote, class, dim; tuser: first; tlast: last
//  m_axis    | out | tvalid / tready    | tdata: value, class, dim, energy, pred; tlast: final
//  cfg       | in  | i_cfg_we (no wait) | i_cfg_addr selects register, i_cfg_wdata
//
//  One vote per clock sustained while m_axis accepts. An input transaction with tlast set yields a result
//  on m_axis through accumulator RMW, shift/clip, square, energy/argmax and the output register.
//  A one-entry write forwarding register covers back-to-back hits on one accumulator entry.
//  Reset (sync, active low) clears valids, energy/argmax state and config; the
//  accumulator RAM is not cleared (first-capsule votes overwrite it).
//  Each stage takes an item when empty or draining; a stalled m_axis blocks input once full.
module capsule_vote_sum_classify_unit #(
    parameter int NUM_CLASSES = cvsc_pkg::NUM_CLASSES_DEF,
    parameter int CAPS_DIM    = cvsc_pkg::CAPS_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] vote_value, [11:8] class_index, [15:12] dim_index
    input  logic [cvsc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] first_capsule
    input  logic [0:0]                      s_axis_tuser,
    input  logic                            s_axis_tlast,
    // Output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] out_value, [11:8] out_class, [15:12] out_dim, [30:16] class_energy,
    // [34:31] predicted_class, [39:35] zero
    output logic [cvsc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast,
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic [cvsc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [cvsc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    import cvsc_pkg::*;

    localparam int DEPTH  = NUM_CLASSES * CAPS_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    // ---------------- configuration ----------------
    logic [RSH_W-1:0] r_route_shift;
    logic [ESH_W-1:0] r_energy_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_shift  <= ROUTE_SHIFT_RST;
            r_energy_shift <= ENERGY_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_ROUTE_SHIFT:  r_route_shift  <= i_cfg_wdata[RSH_W-1:0];
                REG_ENERGY_SHIFT: r_energy_shift <= i_cfg_wdata[ESH_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage ready chain ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic rdy1, rdy2, rdy3, rdy4, rdyo;

    assign rdyo = !r_vo || m_axis_tready;
    assign rdy4 = !r_v4 || rdyo;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign s_axis_tready = rdy1;

    // ---------------- input decode ----------------
    logic                   in_acc;
    logic [VOTE_W-1:0]      in_vote;
    logic [IDX_W-1:0]       in_cls, in_dim;
    logic                   in_range;
    logic [ADDR_FULL_W-1:0] in_addr_full;
    logic [ADDR_W-1:0]      in_addr;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_vote  = s_axis_tdata[7:0];
    assign in_cls   = s_axis_tdata[11:8];
    assign in_dim   = s_axis_tdata[15:12];
    assign in_range = ({1'b0, in_cls} < (IDX_W+1)'(NUM_CLASSES))
                   && ({1'b0, in_dim} < (IDX_W+1)'(CAPS_DIM));
    assign in_addr_full = ADDR_FULL_W'(in_cls) * ADDR_FULL_W'(CAPS_DIM)
                        + ADDR_FULL_W'(in_dim);
    assign in_addr = in_addr_full[ADDR_W-1:0];

    // ---------------- stage 1: accumulator read-modify-write ----------------
    logic [VOTE_W-1:0] r_vote1;
    logic [IDX_W-1:0]  r_cls1, r_dim1;
    logic              r_first1, r_last1;
    logic [ADDR_W-1:0] r_addr1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= in_acc && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_vote1  <= in_vote;
            r_cls1   <= in_cls;
            r_dim1   <= in_dim;
            r_first1 <= s_axis_tuser[0];
            r_last1  <= s_axis_tlast;
            r_addr1  <= in_addr;
        end
    end

    logic [ACC_W-1:0] ram_q;
    logic             wr_en;
    logic [ACC_W-1:0] n_sum;
    logic [ACC_W-1:0] acc_base;
    logic [ACC_W-1:0] vote_ext;

    // Last write, forwarded when the next item hits the same entry
    logic              r_wv;
    logic [ADDR_W-1:0] r_waddr;
    logic [ACC_W-1:0]  r_wdata;

    assign wr_en    = r_v1 && rdy2;
    assign vote_ext = ACC_W'($signed(r_vote1));
    assign acc_base = (r_wv && (r_waddr == r_addr1)) ? r_wdata : ram_q;
    assign n_sum    = r_first1 ? vote_ext : (acc_base + vote_ext);

    cvsc_ram #(
        .WIDTH (ACC_W),
        .DEPTH (DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_addr1),
        .i_wdata (n_sum),
        .i_re    (in_acc),
        .i_raddr (in_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
        end else if (wr_en) begin
            r_wv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_waddr <= r_addr1;
            r_wdata <= n_sum;
        end
    end

    // ---------------- stage 2: shift and clip ----------------
    logic [ACC_W-1:0] r_sum2;
    logic [IDX_W-1:0] r_cls2, r_dim2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1 && r_last1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_sum2 <= n_sum;
            r_cls2 <= r_cls1;
            r_dim2 <= r_dim1;
        end
    end

    logic signed [ACC_W-1:0] sum_sh;
    logic [VOTE_W-1:0]       n_clip;

    // >>> by 24 or more leaves only sign bits
    assign sum_sh = $signed(r_sum2) >>> r_route_shift;

    always_comb begin
        if (sum_sh > CLIP_HI) begin
            n_clip = CLIP_HI[VOTE_W-1:0];
        end else if (sum_sh < CLIP_LO) begin
            n_clip = CLIP_LO[VOTE_W-1:0];
        end else begin
            n_clip = sum_sh[VOTE_W-1:0];
        end
    end

    // ---------------- stage 3: square ----------------
    logic [VOTE_W-1:0] r_val3;
    logic [IDX_W-1:0]  r_cls3, r_dim3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy3) begin
            r_val3 <= n_clip;
            r_cls3 <= r_cls2;
            r_dim3 <= r_dim2;
        end
    end

    logic signed [2*VOTE_W-1:0] prod;
    assign prod = $signed(r_val3) * $signed(r_val3);

    logic [SQ_W-1:0]   r_sq4;
    logic [VOTE_W-1:0] r_val4;
    logic [IDX_W-1:0]  r_cls4, r_dim4;

    // ---------------- stage 4: energy, argmax, output register ----------------
    // r_v4 marks the squared item; energy and argmax update as it moves to the output.
    logic [ENERGY_W-1:0] r_energy, r_best_e;
    logic [IDX_W-1:0]    r_best_cls;

    always_ff @(posedge i_clk) begin
        if (r_v3 && rdy4) begin
            r_sq4  <= prod[SQ_W-1:0];
            r_val4 <= r_val3;
            r_cls4 <= r_cls3;
            r_dim4 <= r_dim3;
        end
    end

    // stage 4 holds squared item; output register sits after it
    logic [SQ_W-1:0]     sq_sh;
    logic [ENERGY_W:0]   e_add;
    logic [ENERGY_W-1:0] e_base, n_energy, best_base, n_best_e;
    logic [IDX_W-1:0]    cls_base, n_best_cls;
    logic                dim_zero, dim_last, restart;

    assign sq_sh    = r_sq4 >> r_energy_shift;
    assign dim_zero = (r_dim4 == '0);
    assign dim_last = (r_dim4 == IDX_W'(CAPS_DIM - 1));
    assign restart  = dim_zero && (r_cls4 == '0);
    assign e_base   = dim_zero ? '0 : r_energy;
    assign e_add    = {1'b0, e_base} + {1'b0, sq_sh};
    assign n_energy = e_add[ENERGY_W] ? ENERGY_MAX : e_add[ENERGY_W-1:0];
    assign best_base = restart ? '0 : r_best_e;
    assign cls_base  = restart ? '0 : r_best_cls;

    always_comb begin
        n_best_e   = best_base;
        n_best_cls = cls_base;
        if (dim_last && (n_energy > best_base)) begin
            n_best_e   = n_energy;
            n_best_cls = r_cls4;
        end
    end

    logic upd;
    assign upd = r_v4 && rdyo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy   <= '0;
            r_best_e   <= '0;
            r_best_cls <= '0;
        end else if (upd) begin
            r_energy   <= n_energy;
            r_best_e   <= n_best_e;
            r_best_cls <= n_best_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (rdyo) begin
            r_vo <= r_v4;
        end
    end

    logic [M_TDATA_W-1:0] r_odata;
    logic                 r_olast;

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_odata <= {5'b0, n_best_cls, n_energy, r_dim4, r_cls4, r_val4};
            r_olast <= dim_last && (r_cls4 == IDX_W'(NUM_CLASSES - 1));
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // ---------------- checks ----------------
    // An empty pipeline must never block the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid && !r_v4 && !r_v3 && !r_v2 && !r_v1) |-> s_axis_tready)
        else $error("input blocked with empty pipeline");

    // The final result always belongs to the last class.
    a_final_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[11:8] == IDX_W'(NUM_CLASSES - 1)))
        else $error("final result on wrong class");

    // Argmax must never point outside the class range.
    a_pred_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, m_axis_tdata[34:31]} < (IDX_W+1)'(NUM_CLASSES)))
        else $error("predicted class out of range");

    // A written accumulator entry is held in the forwarding register in the cycle after the write.
    a_fwd_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_wv && (r_waddr == $past(r_addr1)) && (r_wdata == $past(n_sum))))
        else $error("forwarding register out of step with RAM writes");

endmodule
